/* design/nrbh_pkg.sv */
// nrbh_pkg: shared constants and types for the nearest ray/box hit block.
// No dependencies; imported by every module of the block.

package nrbh_pkg;

    // depth of the queue between the slab pipeline and the running-minimum stage
    localparam int Q_DEPTH      = 8;
    localparam int QCNT_W       = $clog2(Q_DEPTH + 1);
    localparam int QPTR_W       = $clog2(Q_DEPTH);

    // register stages in the slab pipeline
    localparam int FRONT_STAGES = 4;
    localparam int FCNT_W       = $clog2(FRONT_STAGES + 1);

    // configuration register map
    localparam int REG_IDX_W    = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_ORIGIN_X  = 3'd0;
    localparam t_reg_idx REG_ORIGIN_Y  = 3'd1;
    localparam t_reg_idx REG_ORIGIN_Z  = 3'd2;
    localparam t_reg_idx REG_INV_DIR_X = 3'd3;
    localparam t_reg_idx REG_INV_DIR_Y = 3'd4;
    localparam t_reg_idx REG_INV_DIR_Z = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

/* design/nrbh_cfg.sv */
// nrbh_cfg: APB-style register file holding the ray origin and inverse direction.
// Depends on nrbh_pkg for the register map.

module nrbh_cfg #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int PDATA_W     = 32,
    parameter int PADDR_W     = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic signed [COORD_WIDTH-1:0] o_origin  [3],
    output logic signed [COORD_WIDTH-1:0] o_inv_dir [3]
);
    import nrbh_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] r_origin [3];
    logic signed [CW-1:0] r_inv    [3];
    t_reg_idx             reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_origin[a] <= '0;
                // 1.0 in the fixed-point format
                r_inv[a]    <= CW'(1) << FRAC_BITS;
            end
        end else if (wr_en) begin
            case (reg_idx)
                REG_ORIGIN_X:  r_origin[0] <= pwdata[CW-1:0];
                REG_ORIGIN_Y:  r_origin[1] <= pwdata[CW-1:0];
                REG_ORIGIN_Z:  r_origin[2] <= pwdata[CW-1:0];
                REG_INV_DIR_X: r_inv[0]    <= pwdata[CW-1:0];
                REG_INV_DIR_Y: r_inv[1]    <= pwdata[CW-1:0];
                REG_INV_DIR_Z: r_inv[2]    <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ORIGIN_X:  prdata = PDATA_W'($unsigned(r_origin[0]));
            REG_ORIGIN_Y:  prdata = PDATA_W'($unsigned(r_origin[1]));
            REG_ORIGIN_Z:  prdata = PDATA_W'($unsigned(r_origin[2]));
            REG_INV_DIR_X: prdata = PDATA_W'($unsigned(r_inv[0]));
            REG_INV_DIR_Y: prdata = PDATA_W'($unsigned(r_inv[1]));
            REG_INV_DIR_Z: prdata = PDATA_W'($unsigned(r_inv[2]));
            default:       prdata = '0;
        endcase
    end

    assign o_origin  = r_origin;
    assign o_inv_dir = r_inv;

endmodule

/* design/nrbh_front.sv */
// nrbh_front: four-stage slab pipeline; face offsets, scaling by the inverse
// direction, entry/exit reduction and hit classification. Depends on nrbh_pkg.

module nrbh_front #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_center  [3],
    input  logic [COORD_WIDTH-2:0]        i_half    [3],
    input  logic [ID_WIDTH-1:0]           i_box_id,
    input  logic                          i_last_box,
    input  logic signed [COORD_WIDTH-1:0] i_origin  [3],
    input  logic signed [COORD_WIDTH-1:0] i_inv_dir [3],
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_entry,
    output logic                          o_hit,
    output logic [ID_WIDTH-1:0]           o_id,
    output logic                          o_last,
    output logic [nrbh_pkg::FCNT_W-1:0]   o_inflight
);
    import nrbh_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;
    localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_diff(input logic signed [CW+1:0] v);
        logic [2:0] top;
        top = v[CW+1:CW-1];
        if (&top || ~|top) return $signed(v[CW-1:0]);
        return v[CW+1] ? SMIN : SMAX;
    endfunction

    // floor shift of the product, then clamp to the coordinate range
    function automatic logic signed [CW-1:0] sat_prod(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic [CW:0]          top;
        s   = p >>> FRAC_BITS;
        top = s[PW-1:CW-1];
        if (&top || ~|top) return $signed(s[CW-1:0]);
        return s[PW-1] ? SMIN : SMAX;
    endfunction

    logic                 r_vld  [FRONT_STAGES];
    logic [ID_WIDTH-1:0]  r_id   [FRONT_STAGES];
    logic                 r_last [FRONT_STAGES];

    logic signed [CW+1:0] lo_w [3];
    logic signed [CW+1:0] hi_w [3];
    logic signed [CW-1:0] r_d0 [3];
    logic signed [CW-1:0] r_d1 [3];
    logic signed [PW-1:0] r_p0 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic signed [CW-1:0] r_t0 [3];
    logic signed [CW-1:0] r_t1 [3];
    logic signed [CW-1:0] near_t [3];
    logic signed [CW-1:0] far_t  [3];
    logic signed [CW-1:0] n_entry;
    logic signed [CW-1:0] n_exit;
    logic signed [CW-1:0] r_entry;
    logic signed [CW-1:0] r_exit;
    logic [FCNT_W-1:0]    cnt;

    // stage 1: exact faces minus origin, saturated
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo_w[a] = $signed({{2{i_center[a][CW-1]}}, i_center[a]})
                    - $signed({3'b000, i_half[a]})
                    - $signed({{2{i_origin[a][CW-1]}}, i_origin[a]});
            hi_w[a] = $signed({{2{i_center[a][CW-1]}}, i_center[a]})
                    + $signed({3'b000, i_half[a]})
                    - $signed({{2{i_origin[a][CW-1]}}, i_origin[a]});
        end
    end

    // stage 4 inputs: per-axis near/far, then the slab intersection
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            near_t[a] = (r_t0[a] < r_t1[a]) ? r_t0[a] : r_t1[a];
            far_t[a]  = (r_t0[a] < r_t1[a]) ? r_t1[a] : r_t0[a];
        end
        n_entry = (near_t[0] > near_t[1]) ? near_t[0] : near_t[1];
        n_entry = (near_t[2] > n_entry)   ? near_t[2] : n_entry;
        n_exit  = (far_t[0] < far_t[1])   ? far_t[0]  : far_t[1];
        n_exit  = (far_t[2] < n_exit)     ? far_t[2]  : n_exit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRONT_STAGES; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < FRONT_STAGES; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_id[0]   <= i_box_id;
        r_last[0] <= i_last_box;
        for (int k = 1; k < FRONT_STAGES; k++) begin
            r_id[k]   <= r_id[k-1];
            r_last[k] <= r_last[k-1];
        end
        for (int a = 0; a < 3; a++) begin
            r_d0[a] <= sat_diff(lo_w[a]);
            r_d1[a] <= sat_diff(hi_w[a]);
            r_p0[a] <= r_d0[a] * i_inv_dir[a];
            r_p1[a] <= r_d1[a] * i_inv_dir[a];
            r_t0[a] <= sat_prod(r_p0[a]);
            r_t1[a] <= sat_prod(r_p1[a]);
        end
        r_entry <= n_entry;
        r_exit  <= n_exit;
    end

    always_comb begin
        cnt = '0;
        for (int k = 0; k < FRONT_STAGES; k++) cnt = cnt + FCNT_W'(r_vld[k]);
    end

    assign o_valid    = r_vld[FRONT_STAGES-1];
    assign o_entry    = r_entry;
    assign o_hit      = !r_exit[CW-1] && !(r_entry > r_exit);
    assign o_id       = r_id[FRONT_STAGES-1];
    assign o_last     = r_last[FRONT_STAGES-1];
    assign o_inflight = cnt;

endmodule

/* design/nrbh_queue.sv */
// nrbh_queue: show-ahead FIFO between the slab pipeline and the running minimum.
// Depends on nrbh_pkg for depth and control/status types.

module nrbh_queue #(
    parameter int WIDTH = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nrbh_pkg::t_q_ctrl i_ctrl,
    input  logic [WIDTH-1:0]  i_data,
    output logic [WIDTH-1:0]  o_data,
    output nrbh_pkg::t_q_stat o_stat
);
    import nrbh_pkg::*;

    logic [WIDTH-1:0]  r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign do_pop = i_ctrl.pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctrl.push)
                r_wr <= (r_wr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_ctrl.push && !do_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_ctrl.push && do_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) r_mem[r_wr] <= i_data;
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.push && r_cnt == QCNT_W'(Q_DEPTH)))
        else $error("queue written while full");

endmodule

/* design/nrbh_back.sv */
// nrbh_back: running nearest-hit selection and a two-entry result queue.
// Depends on nrbh_pkg.

module nrbh_back #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  logic signed [COORD_WIDTH-1:0] i_head_entry,
    input  logic                          i_head_hit,
    input  logic [ID_WIDTH-1:0]           i_head_id,
    input  logic                          i_head_last,
    output logic                          o_q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic                          o_hit,
    output logic [ID_WIDTH-1:0]           o_hit_id,
    output logic signed [COORD_WIDTH-1:0] o_hit_dist
);
    import nrbh_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic                 r_best_valid;
    logic signed [CW-1:0] r_best_dist;
    logic [ID_WIDTH-1:0]  r_best_id;

    logic                 r_out_hit  [2];
    logic [ID_WIDTH-1:0]  r_out_id   [2];
    logic signed [CW-1:0] r_out_dist [2];
    logic                 r_out_wr;
    logic                 r_out_rd;
    logic [1:0]           r_out_cnt;

    logic                 out_full;
    logic                 out_pop;
    logic                 out_push;
    logic                 take;
    logic                 res_valid;
    logic [ID_WIDTH-1:0]  res_id;
    logic signed [CW-1:0] res_dist;

    assign out_full = (r_out_cnt == 2'd2);
    assign out_pop  = pop && (r_out_cnt != 2'd0);
    assign o_q_pop  = !i_q_empty && (!i_head_last || !out_full);
    assign out_push = o_q_pop && i_head_last;

    // earlier box keeps a tie
    assign take      = i_head_hit && (!r_best_valid || (i_head_entry < r_best_dist));
    assign res_valid = r_best_valid || take;
    assign res_id    = take ? i_head_id    : r_best_id;
    assign res_dist  = take ? i_head_entry : r_best_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_best_valid <= i_head_last ? 1'b0 : res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && take) begin
            r_best_dist <= i_head_entry;
            r_best_id   <= i_head_id;
        end
        if (out_push) begin
            r_out_hit[r_out_wr]  <= res_valid;
            r_out_id[r_out_wr]   <= res_valid ? res_id : '0;
            r_out_dist[r_out_wr] <= res_valid ? res_dist : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= 1'b0;
            r_out_rd  <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            if (out_push) r_out_wr <= ~r_out_wr;
            if (out_pop)  r_out_rd <= ~r_out_rd;
            if (out_push && !out_pop)
                r_out_cnt <= r_out_cnt + 2'd1;
            else if (!out_push && out_pop)
                r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    assign empty      = (r_out_cnt == 2'd0);
    assign o_hit      = r_out_hit[r_out_rd];
    assign o_hit_id   = r_out_id[r_out_rd];
    assign o_hit_dist = r_out_dist[r_out_rd];

    a_out_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result queue count out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_head_last) |=> !r_best_valid)
        else $error("running best not cleared after last box");

    a_last_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_head_last && !out_pop) |=> r_out_cnt == $past(r_out_cnt) + 2'd1)
        else $error("result lost on last box");

endmodule

/* design/nearest_ray_box_hit.sv */
// nearest_ray_box_hit: top level; APB register file, slab pipeline, queue and
// nearest-hit selection. Depends on nrbh_pkg and all nrbh_* modules.
//
// Streams axis-aligned boxes (center, half extents, id) against one ray set up
// through the APB registers (origin and per-axis inverse direction, signed
// fixed point). Accepts one box per clock while full is low. A box passes a
// four-stage slab pipeline (face offsets, multiply by inverse direction, floor
// shift and clamp, entry/exit reduction), waits in an 8-entry queue and is
// folded into the running nearest hit; the first box wins ties. The box
// marked last_box produces one result (hit, id, entry distance; id and
// distance are 0 without a hit) in the two-entry result queue, and the
// running state restarts.
// full rises when the queue plus the boxes still in the pipeline reach eight,
// so a stalled result side backs up into full after at most eight more boxes.
// Registers sit at byte address 4*index (8*index for coordinates wider than
// 32 bits); the user must write them only while no box is in flight (unchecked).

module nearest_ray_box_hit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int ID_WIDTH    = 16,
    localparam int PDATA_W    = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W    = ((COORD_WIDTH > 32) ? 3 : 2) + nrbh_pkg::REG_IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // box requests
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  logic [COORD_WIDTH-2:0]        i_half_x,
    input  logic [COORD_WIDTH-2:0]        i_half_y,
    input  logic [COORD_WIDTH-2:0]        i_half_z,
    input  logic [ID_WIDTH-1:0]           i_box_id,
    input  logic                          i_last_box,
    // results
    input  logic                          pop,
    output logic                          empty,
    output logic                          o_hit,
    output logic [ID_WIDTH-1:0]           o_hit_id,
    output logic signed [COORD_WIDTH-1:0] o_hit_dist,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);
    import nrbh_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int QW = CW + ID_WIDTH + 2;

    logic signed [CW-1:0] origin  [3];
    logic signed [CW-1:0] inv_dir [3];
    logic signed [CW-1:0] center  [3];
    logic [CW-2:0]        half    [3];

    logic                 accept;
    logic                 f_valid;
    logic signed [CW-1:0] f_entry;
    logic                 f_hit;
    logic [ID_WIDTH-1:0]  f_id;
    logic                 f_last;
    logic [FCNT_W-1:0]    inflight;

    t_q_ctrl              q_ctrl;
    t_q_stat              q_stat;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;
    logic                 q_pop;
    logic [QCNT_W:0]      occupancy;

    assign pready = 1'b1;

    assign center[0] = i_center_x;
    assign center[1] = i_center_y;
    assign center[2] = i_center_z;
    assign half[0]   = i_half_x;
    assign half[1]   = i_half_y;
    assign half[2]   = i_half_z;

    // reserve a queue slot for every box inside the pipeline
    assign occupancy = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(inflight);
    assign full      = (occupancy >= (QCNT_W + 1)'(Q_DEPTH));
    assign accept    = push && !full;

    nrbh_cfg #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC_BITS),
        .PDATA_W     (PDATA_W),
        .PADDR_W     (PADDR_W)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_origin  (origin),
        .o_inv_dir (inv_dir)
    );

    nrbh_front #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC_BITS),
        .ID_WIDTH    (ID_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_center   (center),
        .i_half     (half),
        .i_box_id   (i_box_id),
        .i_last_box (i_last_box),
        .i_origin   (origin),
        .i_inv_dir  (inv_dir),
        .o_valid    (f_valid),
        .o_entry    (f_entry),
        .o_hit      (f_hit),
        .o_id       (f_id),
        .o_last     (f_last),
        .o_inflight (inflight)
    );

    assign q_wdata     = {f_hit, f_last, f_id, f_entry};
    assign q_ctrl.push = f_valid;
    assign q_ctrl.pop  = q_pop;

    nrbh_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_data  (q_wdata),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    nrbh_back #(
        .COORD_WIDTH (CW),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_stat.empty),
        .i_head_entry ($signed(q_rdata[CW-1:0])),
        .i_head_hit   (q_rdata[QW-1]),
        .i_head_id    (q_rdata[CW +: ID_WIDTH]),
        .i_head_last  (q_rdata[QW-2]),
        .o_q_pop      (q_pop),
        .pop          (pop),
        .empty        (empty),
        .o_hit        (o_hit),
        .o_hit_id     (o_hit_id),
        .o_hit_dist   (o_hit_dist)
    );

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (QCNT_W + 1)'(Q_DEPTH))
        else $error("queue and pipeline hold more boxes than queue slots");

endmodule
